// File: rtl/assert_macros.svh
// assertion helpers used by the checker file tfp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/tfp_pkg.sv
`default_nettype none

package tfp_pkg;

	localparam int FIELD_COUNT      = 24;
	localparam int FRAME_DATA_BYTES = 34;
	localparam int OUT_TDATA_W      = 40;

	localparam logic [7:0] SOF_BYTE0 = 8'hEA;
	localparam logic [7:0] SOF_BYTE1 = 8'h01;
	localparam logic [7:0] SOF_BYTE2 = 8'hAA;
	localparam logic [7:0] SOF_BYTE3 = 8'hFF;
	localparam logic [7:0] EOF_BYTE  = 8'h0A;

	localparam logic [15:0] MASK_12 = 16'h0FFF;
	localparam logic [7:0]  MASK_6  = 8'h3F;
	localparam logic [7:0]  MASK_4  = 8'h0F;
	localparam logic [7:0]  MASK_2  = 8'h03;

	localparam logic KIND_FIELD = 1'b0;
	localparam logic KIND_CSUM_ERR = 1'b1;

	// frame bytes 4..37, element 0 is frame byte 4
	typedef logic [FRAME_DATA_BYTES-1:0][7:0] frame_t;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [15:0] total;
	} emit_req_t;

	function automatic logic [15:0] field_value(input logic [4:0] idx, input frame_t f);
		logic [15:0] v;
		v = '0;
		unique case (idx)
			5'd0:    v = {f[0],  f[1]};
			5'd1:    v = {f[2],  f[3]};
			5'd2:    v = {f[4],  f[5]};
			5'd3:    v = {f[6],  f[7]};
			5'd4:    v = {f[8],  f[9]};
			5'd5:    v = {f[10], f[11]};
			5'd6:    v = {f[12], f[13]};
			5'd7:    v = {f[14], f[15]} & MASK_12;
			5'd8:    v = {f[16], f[17]} & MASK_12;
			5'd9:    v = {f[18], f[19]} & MASK_12;
			5'd10:   v = {f[20], f[21]};
			5'd11:   v = {8'h00, f[22] & MASK_6};
			5'd12:   v = {8'h00, f[23] & MASK_6};
			5'd13:   v = {8'h00, f[24] & MASK_4};
			5'd14:   v = {8'h00, (f[24] >> 4) & MASK_2};
			5'd15:   v = {8'h00, f[25] & MASK_4};
			5'd16:   v = {8'h00, f[26]};
			5'd17:   v = {8'h00, f[27]};
			5'd18:   v = {8'h00, f[28]};
			5'd19:   v = {8'h00, f[29]};
			5'd20:   v = {8'h00, f[30]};
			5'd21:   v = {8'h00, f[31]};
			5'd22:   v = {8'h00, f[32]};
			5'd23:   v = {8'h00, f[33]};
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/tfp_byte_cell.sv
`default_nettype none

module tfp_byte_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire logic [7:0] d,
	output logic      [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

`default_nettype wire

// File: rtl/tfp_field_emitter.sv
`default_nettype none

module tfp_field_emitter
	import tfp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire emit_req_t              req,
	input  wire frame_t                 frame,
	output logic                        load_ok,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // field_index, field_value, error_total, pad
	output logic                        m_tuser,  // result_kind
	output logic                        m_tlast
);

	localparam logic [4:0] LAST_IDX = 5'(FIELD_COUNT - 1);

	logic        active_q;
	logic        kind_q;
	logic [4:0]  idx_q;
	logic [15:0] total_q;
	frame_t      frame_q;
	logic        last;
	logic [15:0] value;

	assign last    = (kind_q == KIND_CSUM_ERR) || (idx_q == LAST_IDX);
	assign load_ok = !active_q || (m_tready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			kind_q   <= KIND_FIELD;
			idx_q    <= '0;
			total_q  <= '0;
		end else if (req.valid) begin
			active_q <= 1'b1;
			kind_q   <= req.kind;
			idx_q    <= '0;
			total_q  <= req.total;
		end else if (active_q && m_tready) begin
			if (last) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			frame_q <= frame;
		end
	end

	assign value = (kind_q == KIND_CSUM_ERR) ? 16'h0000 : field_value(idx_q, frame_q);

	assign m_tvalid = active_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last;
	assign m_tdata  = {3'b000, total_q, value, idx_q};

endmodule

`default_nettype wire

// File: rtl/telemetry_frame_parser.sv
// A frame's last byte is registered into the window, then the emitter registers its run.
// One byte per cycle unless stalled; one result per cycle while m_tready is high; a valid frame gives 24.
// The input stalls only when a check that produces a result finds the previous run still
// being sent. The window is a 40-cell byte shift chain with a running 8-bit sum.
// Reset (arst_n low) clears the window, counters and output run; no clearing pass.
`default_nettype none

module telemetry_frame_parser
	import tfp_pkg::*;
#(
	parameter int FRAME_LENGTH = 40
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,  // rx_byte
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // field_index, field_value, error_total, pad
	output logic                        m_tuser,  // result_kind
	output logic                        m_tlast   // last_of_run
);

	localparam int FW = $clog2(FRAME_LENGTH + 1);
	localparam logic [FW-1:0] FRESH_FULL = FW'(FRAME_LENGTH);

	logic [FRAME_LENGTH-1:0][7:0] win;
	logic [FRAME_LENGTH-1:0][7:0] win_in;
	logic                         accept;
	logic [FW-1:0]                fresh_q;
	logic [7:0]                   sum_q;
	logic [15:0]                  err_q;
	logic                         chk_q;
	logic                         hit;
	logic                         sum_ok;
	logic                         load_ok;
	logic                         fire;
	logic [15:0]                  err_inc;
	emit_req_t                    req;
	frame_t                       frame;

	assign accept = s_tvalid && s_tready;

	genvar k;
	generate
		for (k = 0; k < FRAME_LENGTH; k++) begin : g_cell
			if (k == FRAME_LENGTH - 1) begin : g_tail
				assign win_in[k] = s_tdata;
			end else begin : g_body
				assign win_in[k] = win[k+1];
			end
			tfp_byte_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (accept),
				.d      (win_in[k]),
				.q      (win[k])
			);
		end
		for (k = 0; k < FRAME_DATA_BYTES; k++) begin : g_frame
			assign frame[k] = win[k+4];
		end
	endgenerate

	assign hit = chk_q && (fresh_q == FRESH_FULL) &&
		(win[0] == SOF_BYTE0) && (win[1] == SOF_BYTE1) &&
		(win[2] == SOF_BYTE2) && (win[3] == SOF_BYTE3) &&
		(win[FRAME_LENGTH-1] == EOF_BYTE);
	assign sum_ok  = (sum_q == win[FRAME_LENGTH-2]);
	assign fire    = hit && load_ok;
	assign err_inc = (err_q != 16'hFFFF) ? err_q + 16'd1 : err_q;

	assign s_tready = !(hit && !load_ok);

	always_comb begin
		req.valid = fire;
		req.kind  = sum_ok ? KIND_FIELD : KIND_CSUM_ERR;
		req.total = sum_ok ? err_q : err_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '0;
			sum_q   <= '0;
			err_q   <= '0;
			chk_q   <= 1'b0;
		end else begin
			chk_q <= accept || (hit && !load_ok);
			if (accept) begin
				sum_q <= sum_q + win[FRAME_LENGTH-2] - win[2];
			end
			if (fire && sum_ok) begin
				fresh_q <= accept ? FW'(1) : '0;
			end else if (accept && fresh_q != FRESH_FULL) begin
				fresh_q <= fresh_q + FW'(1);
			end
			if (fire && !sum_ok) begin
				err_q <= err_inc;
			end
		end
	end

	tfp_field_emitter u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.frame    (frame),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// File: rtl/tfp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tfp_checker
	import tfp_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tuser,
	input wire logic                   m_tlast
);

	localparam logic [4:0] LAST_IDX = 5'(FIELD_COUNT - 1);

	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_SAME(a_err_shape, clk, arst_n, m_tvalid && m_tuser == KIND_CSUM_ERR, m_tlast && m_tdata[20:0] == 21'd0)
	`ASSERT_SAME(a_run_end, clk, arst_n, m_tvalid && m_tuser == KIND_FIELD && m_tlast, m_tdata[4:0] == LAST_IDX)
	`ASSERT_NEXT(a_run_step, clk, arst_n, m_tvalid && m_tready && m_tuser == KIND_FIELD && !m_tlast, m_tvalid && m_tuser == KIND_FIELD && m_tdata[4:0] == $past(m_tdata[4:0]) + 5'd1)
	`ASSERT_NEXT(a_run_total, clk, arst_n, m_tvalid && m_tready && m_tuser == KIND_FIELD && !m_tlast, m_tdata[36:21] == $past(m_tdata[36:21]))

endmodule

bind telemetry_frame_parser tfp_checker u_chk (.*);

`default_nettype wire
